>>> rtl/chm_pkg.sv
package chm_pkg;

    localparam int unsigned ANGLE_FRACTION_BITS = 6;
    localparam int unsigned CORDIC_STEPS        = 31;
    localparam int unsigned FULL_TURN           = 360 << ANGLE_FRACTION_BITS;
    localparam int unsigned HEAD_W              = $clog2(FULL_TURN + 1);
    localparam int unsigned OUT_W               = 15;
    localparam int unsigned WORD_W              = 16;
    localparam int unsigned ANG_W               = 32;
    localparam int unsigned VEC_W               = 37;
    localparam int unsigned CFG_IDX_W           = 8;

    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 8'd3;

    localparam logic [WORD_W-1:0] SCALE_ONE = 16'd4096;
    localparam logic [ANG_W-1:0]  HALF_TURN = 32'h8000_0000;

    localparam logic [ANG_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001
    };

    typedef struct packed {
        logic                    zero;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [ANG_W-1:0]        ang;
    } t_vec;

    typedef struct packed {
        logic             zero;
        logic [ANG_W-1:0] ang;
    } t_angle;

endpackage

>>> rtl/chm_front.sv
module chm_front
    import chm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [WORD_W-1:0] i_raw_x,
    input  logic signed [WORD_W-1:0] i_raw_y,
    input  logic signed [WORD_W-1:0] i_x_offset,
    input  logic signed [WORD_W-1:0] i_y_offset,
    input  logic [WORD_W-1:0]        i_x_scale,
    input  logic [WORD_W-1:0]        i_y_scale,
    output logic                     o_valid,
    output t_vec                     o_vec
);

    logic                      r_v1, r_v2, r_v3;
    logic signed [WORD_W:0]    r_dx, n_dx;
    logic signed [WORD_W+1:0]  r_dy, n_dy;
    logic signed [2*WORD_W:0]  r_px, n_px;
    logic signed [2*WORD_W+1:0] r_py, n_py;
    t_vec                      r_vec, n_vec;

    always_comb begin
        n_dx = (WORD_W+1)'(i_raw_x) - (WORD_W+1)'(i_x_offset);
        n_dy = -(WORD_W+2)'(i_raw_y) - (WORD_W+2)'(i_y_offset);
    end

    always_comb begin
        n_px = (2*WORD_W+1)'(r_dx * $signed({1'b0, i_x_scale}));
        n_py = (2*WORD_W+2)'(r_dy * $signed({1'b0, i_y_scale}));
    end

    always_comb begin
        n_vec.zero = (r_px == '0) && (r_py == '0);
        if (r_px < 0) begin
            n_vec.x   = -VEC_W'(r_px);
            n_vec.y   = -VEC_W'(r_py);
            n_vec.ang = HALF_TURN;
        end else begin
            n_vec.x   = VEC_W'(r_px);
            n_vec.y   = VEC_W'(r_py);
            n_vec.ang = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_px  <= n_px;
        r_py  <= n_py;
        r_vec <= n_vec;
    end

    assign o_valid = r_v3;
    assign o_vec   = r_vec;

endmodule

>>> rtl/chm_cordic.sv
module chm_cordic
    import chm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_vec   i_vec,
    output logic   o_valid,
    output t_angle o_angle
);

    t_vec r_stage [CORDIC_STEPS];
    logic r_vld   [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        t_vec                    src;
        logic                    src_vld;
        t_vec                    n_stage;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;

        if (i == 0) begin : g_first
            assign src     = i_vec;
            assign src_vld = i_valid;
        end else begin : g_next
            assign src     = r_stage[i-1];
            assign src_vld = r_vld[i-1];
        end

        always_comb begin
            dx           = src.y >>> i;
            dy           = src.x >>> i;
            n_stage.zero = src.zero;
            if (!src.y[VEC_W-1]) begin
                n_stage.x   = src.x + dx;
                n_stage.y   = src.y - dy;
                n_stage.ang = src.ang + ATAN_TABLE[i];
            end else begin
                n_stage.x   = src.x - dx;
                n_stage.y   = src.y + dy;
                n_stage.ang = src.ang - ATAN_TABLE[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_stage[i] <= n_stage;
        end
    end

    assign o_valid      = r_vld[CORDIC_STEPS-1];
    assign o_angle.zero = r_stage[CORDIC_STEPS-1].zero;
    assign o_angle.ang  = r_stage[CORDIC_STEPS-1].ang;

endmodule

>>> rtl/chm_scale.sv
module chm_scale
    import chm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_angle           i_angle,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_heading
);

    localparam int unsigned PROD_W = ANG_W + HEAD_W;

    logic              r_v1, r_v2;
    logic              r_zero;
    logic [PROD_W-1:0] n_prod;
    logic [HEAD_W-1:0] r_h;
    logic [OUT_W-1:0]  r_heading, n_heading;

    always_comb begin
        n_prod = PROD_W'(i_angle.ang) * PROD_W'(FULL_TURN) + PROD_W'(HALF_TURN);
    end

    always_comb begin
        if (r_zero || (r_h >= HEAD_W'(FULL_TURN))) begin
            n_heading = '0;
        end else begin
            n_heading = OUT_W'(r_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero    <= i_angle.zero;
        r_h       <= n_prod[PROD_W-1:ANG_W];
        r_heading <= n_heading;
    end

    assign o_valid   = r_v2;
    assign o_heading = r_heading;

endmodule

>>> rtl/compass_heading_from_raw_field.sv
// Compass heading from one magnetometer sample.
// A sample is transferred at a rising edge with start high and busy low. The
// block is a pipeline of 36 register stages and busy is never raised, so a new
// sample may be transferred in every cycle.
// Each result appears on o_heading_angle with o_valid high for exactly one
// cycle, once its sample has passed through every register stage, in sample
// order.
// The stages are offset subtraction, scale multiplication, half-turn
// pre-rotation, one CORDIC micro-rotation per stage for 31 stages, the
// conversion to 1/64 degree, and the full-turn wrap.
// The receiver cannot stall, so results are never held back.
// Calibration registers are written over the cfg channel (index and data),
// which is always ready; indexes beyond the four registers are ignored.
// Writes should only happen while no sample is in flight.
// Synchronous reset clears the pipeline valid bits, sets both offsets to zero
// and both scales to 1.0.
module compass_heading_from_raw_field
    import chm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [WORD_W-1:0] i_raw_x,
    input  logic signed [WORD_W-1:0] i_raw_y,
    output logic                     o_valid,
    output logic [OUT_W-1:0]         o_heading_angle,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [WORD_W-1:0]        i_cfg_data
);

    logic [WORD_W-1:0] r_x_offset, r_y_offset, r_x_scale, r_y_scale;
    logic              in_xfer;
    logic              front_vld, cordic_vld;
    t_vec              front_vec;
    t_angle            cordic_ang;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset <= '0;
            r_y_offset <= '0;
            r_x_scale  <= SCALE_ONE;
            r_y_scale  <= SCALE_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_X_OFFSET: r_x_offset <= i_cfg_data;
                REG_Y_OFFSET: r_y_offset <= i_cfg_data;
                REG_X_SCALE:  r_x_scale  <= i_cfg_data;
                REG_Y_SCALE:  r_y_scale  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    chm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_xfer),
        .i_raw_x    (i_raw_x),
        .i_raw_y    (i_raw_y),
        .i_x_offset ($signed(r_x_offset)),
        .i_y_offset ($signed(r_y_offset)),
        .i_x_scale  (r_x_scale),
        .i_y_scale  (r_y_scale),
        .o_valid    (front_vld),
        .o_vec      (front_vec)
    );

    chm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_vld),
        .i_vec   (front_vec),
        .o_valid (cordic_vld),
        .o_angle (cordic_ang)
    );

    chm_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (cordic_vld),
        .i_angle   (cordic_ang),
        .o_valid   (o_valid),
        .o_heading (o_heading_angle)
    );

endmodule
